// ===== hdl/assert_macros.svh =====
// assert_macros.svh
// Concurrent assertion helpers used by the block partition index modules.
// No dependencies; expects clk and rst_n in the including module's scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define BPI_ASSERT(name, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define BPI_NEVER(name, cond, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define BPI_ASSERT(name, prop, msg)
`define BPI_NEVER(name, cond, msg)
`endif
`endif

// ===== hdl/bpi_pkg.sv =====
// bpi_pkg.sv
// Shared types and constants of the block partition index core.
// No dependencies.
package bpi_pkg;

    // Configuration register map
    localparam int CFG_ADDR_W = 1;
    localparam logic [CFG_ADDR_W-1:0] REG_TOTAL_ITEMS = 1'b0;
    localparam logic [CFG_ADDR_W-1:0] REG_BIN_COUNT   = 1'b1;

    // Setup sequencer: recomputes quotient, remainder and big-bin span
    typedef enum logic [1:0] {
        SET_IDLE,
        SET_LOAD,
        SET_DIV,
        SET_MUL
    } bpi_setup_state_t;

    // Per-query classification carried from front to back
    typedef struct packed {
        logic e_bad;    // element index not below total items, or bin count zero
        logic k_bad;    // bin number not below bin count
        logic sel_big;  // element lies in the larger bins
        logic own_ok;   // owner and offset are meaningful
        logic k_small;  // queried bin is one of the larger bins
    } bpi_flags_t;

endpackage

// ===== hdl/bpi_queue.sv =====
// bpi_queue.sv
// Small register FIFO between the query front end and the divider pipeline.
// Depends on assert_macros.svh. DEPTH must be a power of two.
`include "assert_macros.svh"

module bpi_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] pop_data,
    output logic             empty
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full     = (count_reg == CNT_W'(DEPTH));
    assign empty    = (count_reg == '0);
    assign pop_data = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    `BPI_NEVER(a_push_full, push && full, "queue written while full")
    `BPI_NEVER(a_pop_empty, pop && empty, "queue read while empty")

endmodule

// ===== hdl/bpi_setup.sv =====
// bpi_setup.sv
// Configuration registers and the sequencer that derives b = N / M, r = N mod M
// and the big-bin span r * (b + 1). Depends on bpi_pkg and assert_macros.svh.
`include "assert_macros.svh"

module bpi_setup #(
    parameter int INDEX_WIDTH = 32
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [bpi_pkg::CFG_ADDR_W-1:0]  cfg_addr,
    input  logic [INDEX_WIDTH-1:0]          cfg_wdata,
    output logic [INDEX_WIDTH-1:0]          total_items,
    output logic [INDEX_WIDTH-1:0]          bin_count,
    output logic [INDEX_WIDTH-1:0]          bin_base,
    output logic [INDEX_WIDTH-1:0]          bin_extra,
    output logic [INDEX_WIDTH-1:0]          big_span,
    output logic                            busy
);

    localparam int W     = INDEX_WIDTH;
    localparam int CNT_W = $clog2(W);
    localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(W - 1);

    bpi_pkg::bpi_setup_state_t state_reg, state_next;

    logic [W-1:0]     total_reg, total_next;
    logic [W-1:0]     count_reg, count_next;
    logic [W-1:0]     base_reg, base_next;
    logic [W-1:0]     extra_reg, extra_next;
    logic [W-1:0]     span_reg, span_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [W-1:0]     wquo_reg, wquo_next;
    logic [W-1:0]     wrem_reg, wrem_next;
    logic [W-1:0]     mcand_reg, mcand_next;
    logic [W-1:0]     mplier_reg, mplier_next;
    logic [W-1:0]     acc_reg, acc_next;

    logic         do_load, do_div, do_mul;
    logic [W:0]   trial, trial_diff;
    logic         trial_ge;
    logic [W-1:0] div_quo, div_rem, mul_acc;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            bpi_pkg::SET_IDLE: state_next = bpi_pkg::SET_IDLE;
            bpi_pkg::SET_LOAD: state_next = bpi_pkg::SET_DIV;
            bpi_pkg::SET_DIV:
            begin
                if (cnt_reg == '0)
                begin
                    state_next = bpi_pkg::SET_MUL;
                end
            end
            bpi_pkg::SET_MUL:
            begin
                if (cnt_reg == '0)
                begin
                    state_next = bpi_pkg::SET_IDLE;
                end
            end
        endcase
        if (cfg_we)
        begin
            state_next = bpi_pkg::SET_LOAD;
        end
    end

    // state outputs
    always_comb
    begin
        do_load = 1'b0;
        do_div  = 1'b0;
        do_mul  = 1'b0;
        unique case (state_reg)
            bpi_pkg::SET_IDLE: do_load = 1'b0;
            bpi_pkg::SET_LOAD: do_load = 1'b1;
            bpi_pkg::SET_DIV:  do_div  = 1'b1;
            bpi_pkg::SET_MUL:  do_mul  = 1'b1;
        endcase
    end

    // restoring divide step and shift-add multiply step
    always_comb
    begin
        trial      = {wrem_reg, wquo_reg[W-1]};
        trial_diff = trial - {1'b0, count_reg};
        trial_ge   = (trial >= {1'b0, count_reg});
        div_rem    = trial_ge ? trial_diff[W-1:0] : trial[W-1:0];
        div_quo    = {wquo_reg[W-2:0], trial_ge};
        mul_acc    = acc_reg + (mplier_reg[0] ? mcand_reg : '0);
    end

    always_comb
    begin
        total_next  = total_reg;
        count_next  = count_reg;
        base_next   = base_reg;
        extra_next  = extra_reg;
        span_next   = span_reg;
        cnt_next    = cnt_reg;
        wquo_next   = wquo_reg;
        wrem_next   = wrem_reg;
        mcand_next  = mcand_reg;
        mplier_next = mplier_reg;
        acc_next    = acc_reg;

        if (cfg_we)
        begin
            unique case (cfg_addr)
                bpi_pkg::REG_TOTAL_ITEMS: total_next = cfg_wdata;
                bpi_pkg::REG_BIN_COUNT:   count_next = cfg_wdata;
            endcase
        end

        if (do_load)
        begin
            wquo_next = total_reg;
            wrem_next = '0;
            cnt_next  = LAST_STEP;
        end

        if (do_div)
        begin
            wquo_next = div_quo;
            wrem_next = div_rem;
            cnt_next  = cnt_reg - 1'b1;
            if (cnt_reg == '0)
            begin
                base_next   = div_quo;
                extra_next  = div_rem;
                mcand_next  = div_quo + 1'b1;
                mplier_next = div_rem;
                acc_next    = '0;
                cnt_next    = LAST_STEP;
            end
        end

        if (do_mul)
        begin
            acc_next    = mul_acc;
            mcand_next  = mcand_reg << 1;
            mplier_next = mplier_reg >> 1;
            cnt_next    = cnt_reg - 1'b1;
            if (cnt_reg == '0)
            begin
                span_next = mul_acc;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= bpi_pkg::SET_IDLE;
            total_reg <= '0;
            count_reg <= {{(W-1){1'b0}}, 1'b1};
            base_reg  <= '0;
            extra_reg <= '0;
            span_reg  <= '0;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            total_reg <= total_next;
            count_reg <= count_next;
            base_reg  <= base_next;
            extra_reg <= extra_next;
            span_reg  <= span_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        wquo_reg   <= wquo_next;
        wrem_reg   <= wrem_next;
        mcand_reg  <= mcand_next;
        mplier_reg <= mplier_next;
        acc_reg    <= acc_next;
    end

    assign total_items = total_reg;
    assign bin_count   = count_reg;
    assign bin_base    = base_reg;
    assign bin_extra   = extra_reg;
    assign big_span    = span_reg;
    assign busy        = (state_reg != bpi_pkg::SET_IDLE);

    `BPI_ASSERT(a_cfg_busy, cfg_we |=> busy, "config write did not start recompute")
    `BPI_ASSERT(a_span_bound, $fell(busy) && count_reg != '0 |-> span_reg <= total_reg, "big-bin span exceeds total items")

endmodule

// ===== hdl/bpi_front.sv =====
// bpi_front.sv
// Query front end: range checks, big/small bin selection, then the queue.
// Depends on bpi_pkg and bpi_queue.
module bpi_front #(
    parameter int INDEX_WIDTH = 32,
    parameter int QUEUE_DEPTH = 4
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    s_tvalid,
    output logic                    s_tready,
    input  logic [INDEX_WIDTH-1:0]  element_index,
    input  logic [INDEX_WIDTH-1:0]  bin_number,
    input  logic [INDEX_WIDTH-1:0]  total_items,
    input  logic [INDEX_WIDTH-1:0]  bin_count,
    input  logic [INDEX_WIDTH-1:0]  bin_base,
    input  logic [INDEX_WIDTH-1:0]  bin_extra,
    input  logic [INDEX_WIDTH-1:0]  big_span,
    input  logic                    setup_busy,
    input  logic                    q_pop,
    output logic                    q_valid,
    output bpi_pkg::bpi_flags_t     q_flags,
    output logic [INDEX_WIDTH-1:0]  q_dividend,
    output logic [INDEX_WIDTH-1:0]  q_bin,
    output logic [INDEX_WIDTH-1:0]  q_start_add
);

    localparam int W      = INDEX_WIDTH;
    localparam int WORD_W = $bits(bpi_pkg::bpi_flags_t) + 3 * W;

    bpi_pkg::bpi_flags_t flags;
    logic [W-1:0]        dividend, start_add;
    logic [WORD_W-1:0]   push_word, pop_word;
    logic                push, full, empty;
    logic                no_bins;

    always_comb
    begin
        no_bins       = (bin_count == '0);
        flags.e_bad   = no_bins || (element_index >= total_items);
        flags.k_bad   = no_bins || (bin_number >= bin_count);
        flags.sel_big = (element_index < big_span);
        flags.own_ok  = !flags.e_bad && (flags.sel_big || (bin_base != '0));
        flags.k_small = (bin_number < bin_extra);
        dividend      = flags.sel_big ? element_index : element_index - big_span;
        // start = k * b + min(k, r); the min term rides along as the accumulator seed
        start_add     = flags.k_small ? bin_number : bin_extra;
    end

    assign s_tready  = !setup_busy && !full;
    assign push      = s_tvalid && s_tready;
    assign push_word = {flags, dividend, bin_number, start_add};
    assign q_valid   = !empty;
    assign {q_flags, q_dividend, q_bin, q_start_add} = pop_word;

    bpi_queue #(
        .WIDTH (WORD_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_word),
        .full      (full),
        .pop       (q_pop),
        .pop_data  (pop_word),
        .empty     (empty)
    );

endmodule

// ===== hdl/bpi_back.sv =====
// bpi_back.sv
// Back end: one restoring-divide bit and one shift-add multiply bit per stage,
// then the result register. Depends on bpi_pkg and assert_macros.svh.
`include "assert_macros.svh"

module bpi_back #(
    parameter int INDEX_WIDTH = 32
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic [INDEX_WIDTH-1:0]  bin_base,
    input  logic [INDEX_WIDTH-1:0]  bin_extra,
    input  logic                    q_valid,
    output logic                    q_pop,
    input  bpi_pkg::bpi_flags_t     q_flags,
    input  logic [INDEX_WIDTH-1:0]  q_dividend,
    input  logic [INDEX_WIDTH-1:0]  q_bin,
    input  logic [INDEX_WIDTH-1:0]  q_start_add,
    output logic                    m_tvalid,
    input  logic                    m_tready,
    output logic [INDEX_WIDTH-1:0]  owner_bin,
    output logic [INDEX_WIDTH-1:0]  offset_in_bin,
    output logic [INDEX_WIDTH-1:0]  bin_size,
    output logic [INDEX_WIDTH-1:0]  bin_start,
    output logic [INDEX_WIDTH-1:0]  bin_end,
    output logic                    element_out_of_range,
    output logic                    bin_out_of_range
);

    localparam int W = INDEX_WIDTH;

    logic         advance;
    logic [W-1:0] bin_big;

    logic                st_valid_reg [W];
    bpi_pkg::bpi_flags_t st_flags_reg [W];
    logic [W-1:0]        st_rem_reg   [W];
    logic [W-1:0]        st_quo_reg   [W];
    logic [W-1:0]        st_div_reg   [W];
    logic [W-1:0]        st_bin_reg   [W];
    logic [W-1:0]        st_acc_reg   [W];

    logic                out_valid_reg, out_valid_next;
    logic [W-1:0]        owner_reg, owner_next;
    logic [W-1:0]        offset_reg, offset_next;
    logic [W-1:0]        size_reg, size_next;
    logic [W-1:0]        start_reg, start_next;
    logic [W-1:0]        end_reg, end_next;
    logic                eoor_reg, eoor_next;
    logic                koor_reg, koor_next;

    bpi_pkg::bpi_flags_t last_flags;
    logic [W-1:0]        size_raw;

    // whole pipeline moves together whenever the result register can take a word
    assign advance = !out_valid_reg || m_tready;
    assign q_pop   = advance && q_valid;
    assign bin_big = bin_base + 1'b1;

    for (genvar i = 0; i < W; i++)
    begin : g_stage
        logic                src_valid;
        bpi_pkg::bpi_flags_t src_flags;
        logic [W-1:0]        src_rem, src_quo, src_div, src_bin, src_acc;
        logic [W:0]          trial, trial_diff;
        logic                trial_ge;
        logic [W-1:0]        rem_next, quo_next, acc_next, part;

        if (i == 0)
        begin : g_head
            assign src_valid = q_valid;
            assign src_flags = q_flags;
            assign src_rem   = '0;
            assign src_quo   = q_dividend;
            assign src_div   = q_flags.sel_big ? bin_big : bin_base;
            assign src_bin   = q_bin;
            assign src_acc   = q_start_add;
        end
        else
        begin : g_body
            assign src_valid = st_valid_reg[i-1];
            assign src_flags = st_flags_reg[i-1];
            assign src_rem   = st_rem_reg[i-1];
            assign src_quo   = st_quo_reg[i-1];
            assign src_div   = st_div_reg[i-1];
            assign src_bin   = st_bin_reg[i-1];
            assign src_acc   = st_acc_reg[i-1];
        end

        always_comb
        begin
            trial      = {src_rem, src_quo[W-1]};
            trial_diff = trial - {1'b0, src_div};
            trial_ge   = (trial >= {1'b0, src_div});
            rem_next   = trial_ge ? trial_diff[W-1:0] : trial[W-1:0];
            quo_next   = {src_quo[W-2:0], trial_ge};
            part       = src_bin[i] ? (bin_base << i) : '0;
            acc_next   = src_acc + part;
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                st_valid_reg[i] <= 1'b0;
            end
            else if (advance)
            begin
                st_valid_reg[i] <= src_valid;
            end
        end

        always_ff @(posedge clk)
        begin
            if (advance)
            begin
                st_flags_reg[i] <= src_flags;
                st_rem_reg[i]   <= rem_next;
                st_quo_reg[i]   <= quo_next;
                st_div_reg[i]   <= src_div;
                st_bin_reg[i]   <= src_bin;
                st_acc_reg[i]   <= acc_next;
            end
        end
    end

    always_comb
    begin
        last_flags     = st_flags_reg[W-1];
        out_valid_next = st_valid_reg[W-1];
        size_raw       = last_flags.k_small ? bin_big : bin_base;
        owner_next     = '0;
        offset_next    = '0;
        if (last_flags.own_ok)
        begin
            owner_next  = last_flags.sel_big ? st_quo_reg[W-1]
                                             : st_quo_reg[W-1] + bin_extra;
            offset_next = st_rem_reg[W-1];
        end
        size_next  = last_flags.k_bad ? '0 : size_raw;
        start_next = last_flags.k_bad ? '0 : st_acc_reg[W-1];
        end_next   = last_flags.k_bad ? '0 : st_acc_reg[W-1] + size_raw;
        eoor_next  = last_flags.e_bad;
        koor_next  = last_flags.k_bad;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            owner_reg  <= owner_next;
            offset_reg <= offset_next;
            size_reg   <= size_next;
            start_reg  <= start_next;
            end_reg    <= end_next;
            eoor_reg   <= eoor_next;
            koor_reg   <= koor_next;
        end
    end

    assign m_tvalid             = out_valid_reg;
    assign owner_bin            = owner_reg;
    assign offset_in_bin        = offset_reg;
    assign bin_size             = size_reg;
    assign bin_start            = start_reg;
    assign bin_end              = end_reg;
    assign element_out_of_range = eoor_reg;
    assign bin_out_of_range     = koor_reg;

    `BPI_ASSERT(a_eoor_zero, out_valid_reg && eoor_reg |-> owner_reg == '0 && offset_reg == '0, "owner/offset not zero on bad element")
    `BPI_ASSERT(a_koor_zero, out_valid_reg && koor_reg |-> size_reg == '0 && end_reg == '0, "bin extent not zero on bad bin")

endmodule

// ===== hdl/block_partition_index_core.sv =====
// block_partition_index_core.sv
// Top level of the block partition index core: setup, front end and back end.
// Depends on bpi_pkg, bpi_setup, bpi_front and bpi_back.
//
// N items are split into M contiguous bins; the first N mod M bins hold one extra item.
// cfg_we/cfg_addr/cfg_wdata set N (index 0) and M (index 1). Each s_axis word carries
// an element index and a bin number; the matching m_axis word gives the owning bin and
// the offset of the element, and size, start and end of the queried bin.
// Out-of-range flags travel in m_axis_tuser and force the related fields to zero.
// Throughput is one word per cycle on both sides while m_axis_tready is high and no
// recompute runs. A word accepted passes through the queue, then INDEX_WIDTH
// divide/multiply stages, one quotient bit each, into the result register, from
// which the m_axis side takes it.
// Each register write starts a recompute of N / M, N mod M and the big-bin span;
// s_axis_tready stays low from the write edge until the recompute is done.
// Write only while no queries are in flight.
// Reset gives N = 0, M = 1 and an empty pipeline; s_axis_tready is already high during
// reset, so s_axis_tvalid must stay low until rst_n is released.
// With m_axis_tready low and a word waiting the pipeline holds; the QUEUE_DEPTH entry
// queue takes further queries until full, then s_axis_tready drops.
module block_partition_index_core #(
    parameter int INDEX_WIDTH = 32,
    parameter int QUEUE_DEPTH = 4
) (
    input  logic                              clk,
    input  logic                              rst_n,
    // configuration write port
    input  logic                              cfg_we,
    input  logic [bpi_pkg::CFG_ADDR_W-1:0]    cfg_addr,
    input  logic [INDEX_WIDTH-1:0]            cfg_wdata,
    // query words
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // from bit 0 up: element_index, bin_number, zero pad
    input  logic [((2*INDEX_WIDTH+7)/8)*8-1:0] s_axis_tdata,
    // result words
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // from bit 0 up: owner_bin, offset_in_bin, bin_size, bin_start, bin_end, zero pad
    output logic [((5*INDEX_WIDTH+7)/8)*8-1:0] m_axis_tdata,
    // from bit 0 up: element_out_of_range, bin_out_of_range
    output logic [1:0]                        m_axis_tuser
);

    localparam int W          = INDEX_WIDTH;
    localparam int OUT_DATA_W = ((5 * W + 7) / 8) * 8;

    logic [W-1:0] element_index, bin_number;
    logic [W-1:0] total_items, bin_count, bin_base, bin_extra, big_span;
    logic         setup_busy;

    logic                q_valid, q_pop;
    bpi_pkg::bpi_flags_t q_flags;
    logic [W-1:0]        q_dividend, q_bin, q_start_add;

    logic [W-1:0] owner_bin, offset_in_bin, bin_size, bin_start, bin_end;
    logic         element_out_of_range, bin_out_of_range;

    assign element_index = s_axis_tdata[W-1:0];
    assign bin_number    = s_axis_tdata[2*W-1:W];

    // derived constants; user keeps them stable with queries in flight (unenforced)
    bpi_setup #(
        .INDEX_WIDTH (INDEX_WIDTH)
    ) u_setup (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_addr    (cfg_addr),
        .cfg_wdata   (cfg_wdata),
        .total_items (total_items),
        .bin_count   (bin_count),
        .bin_base    (bin_base),
        .bin_extra   (bin_extra),
        .big_span    (big_span),
        .busy        (setup_busy)
    );

    // range checks and dividend selection, then the queue
    bpi_front #(
        .INDEX_WIDTH (INDEX_WIDTH),
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_tvalid      (s_axis_tvalid),
        .s_tready      (s_axis_tready),
        .element_index (element_index),
        .bin_number    (bin_number),
        .total_items   (total_items),
        .bin_count     (bin_count),
        .bin_base      (bin_base),
        .bin_extra     (bin_extra),
        .big_span      (big_span),
        .setup_busy    (setup_busy),
        .q_pop         (q_pop),
        .q_valid       (q_valid),
        .q_flags       (q_flags),
        .q_dividend    (q_dividend),
        .q_bin         (q_bin),
        .q_start_add   (q_start_add)
    );

    // bit-per-stage divide and multiply, result register
    bpi_back #(
        .INDEX_WIDTH (INDEX_WIDTH)
    ) u_back (
        .clk                  (clk),
        .rst_n                (rst_n),
        .bin_base             (bin_base),
        .bin_extra            (bin_extra),
        .q_valid              (q_valid),
        .q_pop                (q_pop),
        .q_flags              (q_flags),
        .q_dividend           (q_dividend),
        .q_bin                (q_bin),
        .q_start_add          (q_start_add),
        .m_tvalid             (m_axis_tvalid),
        .m_tready             (m_axis_tready),
        .owner_bin            (owner_bin),
        .offset_in_bin        (offset_in_bin),
        .bin_size             (bin_size),
        .bin_start            (bin_start),
        .bin_end              (bin_end),
        .element_out_of_range (element_out_of_range),
        .bin_out_of_range     (bin_out_of_range)
    );

    assign m_axis_tdata = OUT_DATA_W'({bin_end, bin_start, bin_size, offset_in_bin, owner_bin});
    assign m_axis_tuser = {bin_out_of_range, element_out_of_range};

endmodule
